[sv/cma_pkg.sv]
`default_nettype none
package cma_pkg;

  localparam int MAX_CLASSES = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = $clog2(MAX_CLASSES);
  localparam int CELLS       = MAX_CLASSES * MAX_CLASSES;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int SCORE_W     = 32;
  localparam int CFG_W       = 5;
  localparam int FRAC_W      = 17;
  localparam int STEP_W      = $clog2(FRAC_W + 1);

  localparam logic [CFG_W-1:0] CLASS_COUNT_RST = CFG_W'(MAX_CLASSES);
  localparam logic [CFG_W-1:0] CLASS_COUNT_MIN = CFG_W'(2);
  localparam logic [CFG_W-1:0] CLASS_COUNT_MAX = CFG_W'(MAX_CLASSES);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [1:0] {
    OP_SCORE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] pred_idx;
    logic [IDX_W-1:0] true_idx;
  } am_res_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quot;
  } div_res_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

endpackage
`default_nettype wire

[sv/confusion_matrix_accumulator.sv]
// flow: a vector's last element reads its cell, then its result enters the output
// register once free; a read answer waits on the 17-step shift-subtract divider
// score elements and clears are taken one per cycle while idle; no new item is
// taken until a vector's or read's result is in the output register, where it waits
// reset: synchronous active-low; matrix cleared at once by per-cell valid flops,
// no clearing pass, class_count returns to 16
`default_nettype none
module confusion_matrix_accumulator (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           in_opcode,
  input  wire logic signed [cma_pkg::SCORE_W-1:0]   in_pred_score,
  input  wire logic signed [cma_pkg::SCORE_W-1:0]   in_true_score,
  input  wire logic [cma_pkg::IDX_W-1:0]            in_row_index,
  input  wire logic [cma_pkg::IDX_W-1:0]            in_col_index,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_result_kind,
  output logic [cma_pkg::IDX_W-1:0]                 out_pred_class,
  output logic [cma_pkg::IDX_W-1:0]                 out_true_class,
  output logic [cma_pkg::COUNT_WIDTH-1:0]           out_cell_count,
  output logic [cma_pkg::COUNT_WIDTH-1:0]           out_correct_count,
  output logic [cma_pkg::COUNT_WIDTH-1:0]           out_sample_total,
  output logic [cma_pkg::FRAC_W-1:0]                out_accuracy_fraction,
  input  wire logic                                 cfg_write_en,
  input  wire logic [cma_pkg::CFG_W-1:0]            cfg_write_data
);

  cma_pkg::state_t   state_r, state_nxt;
  cma_pkg::am_res_t  am;
  cma_pkg::div_res_t dv;

  logic [cma_pkg::CFG_W-1:0]       class_count_r;
  logic [cma_pkg::COUNT_WIDTH-1:0] diag_r, total_r;
  logic [cma_pkg::IDX_W-1:0]       pend_pred_r, pend_true_r;
  logic [cma_pkg::CELLS-1:0]       cell_vld_r;
  logic                            rd_vld_r;

  logic                            accept, slot_free;
  logic                            score_step, clear_all, rd_en, div_start;
  logic                            upd_fire, ans_fire;
  logic [cma_pkg::ADDR_W-1:0]      rd_addr, wr_addr;
  logic [cma_pkg::COUNT_WIDTH-1:0] ram_rdata, cell_cur, cell_inc, diag_inc, total_inc;

  logic                            out_valid_r, out_kind_r;
  logic [cma_pkg::IDX_W-1:0]       out_pred_r, out_true_r;
  logic [cma_pkg::COUNT_WIDTH-1:0] out_cell_r, out_corr_r, out_total_r;
  logic [cma_pkg::FRAC_W-1:0]      out_acc_r;

  assign in_ready  = (state_r == cma_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cma_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            cma_pkg::OP_SCORE: state_nxt = am.last ? cma_pkg::ST_UPDATE : cma_pkg::ST_IDLE;
            cma_pkg::OP_READ:  state_nxt = cma_pkg::ST_DIVIDE;
            default:           state_nxt = cma_pkg::ST_IDLE;
          endcase
        end
      end
      cma_pkg::ST_UPDATE: begin
        if (slot_free) begin
          state_nxt = cma_pkg::ST_IDLE;
        end
      end
      cma_pkg::ST_DIVIDE: begin
        if (dv.done && slot_free) begin
          state_nxt = cma_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    score_step = accept && (in_opcode == cma_pkg::OP_SCORE);
    clear_all  = accept && (in_opcode == cma_pkg::OP_CLEAR);
    div_start  = accept && (in_opcode == cma_pkg::OP_READ);
    rd_en      = div_start || (score_step && am.last);
    rd_addr    = div_start ? {in_row_index, in_col_index} : {am.true_idx, am.pred_idx};
    upd_fire   = (state_r == cma_pkg::ST_UPDATE) && slot_free;
    ans_fire   = (state_r == cma_pkg::ST_DIVIDE) && dv.done && slot_free;
  end

  cma_argmax u_argmax (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (score_step),
    .pred_score (in_pred_score),
    .true_score (in_true_score),
    .class_count(class_count_r),
    .res        (am)
  );

  cma_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(diag_r),
    .divisor (total_r),
    .res     (dv)
  );

  assign wr_addr   = {pend_true_r, pend_pred_r};
  assign cell_cur  = rd_vld_r ? ram_rdata : '0;
  assign cell_inc  = cma_pkg::sat_inc(cell_cur);
  assign diag_inc  = cma_pkg::sat_inc(diag_r);
  assign total_inc = cma_pkg::sat_inc(total_r);

  cma_ram #(
    .WIDTH(cma_pkg::COUNT_WIDTH),
    .DEPTH(cma_pkg::CELLS)
  ) u_counts (
    .clk  (clk),
    .we   (upd_fire),
    .waddr(wr_addr),
    .wdata(cell_inc),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= cma_pkg::ST_IDLE;
      class_count_r <= cma_pkg::CLASS_COUNT_RST;
      diag_r        <= '0;
      total_r       <= '0;
      cell_vld_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write_en) begin
        class_count_r <= cfg_write_data;
      end
      if (clear_all) begin
        diag_r     <= '0;
        total_r    <= '0;
        cell_vld_r <= '0;
      end else if (upd_fire) begin
        total_r             <= total_inc;
        cell_vld_r[wr_addr] <= 1'b1;
        if (pend_pred_r == pend_true_r) begin
          diag_r <= diag_inc;
        end
      end
      if (upd_fire || ans_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (score_step && am.last) begin
      pend_pred_r <= am.pred_idx;
      pend_true_r <= am.true_idx;
    end
    if (rd_en) begin
      rd_vld_r <= cell_vld_r[rd_addr];
    end
    if (upd_fire) begin
      out_kind_r  <= cma_pkg::KIND_SAMPLE;
      out_pred_r  <= pend_pred_r;
      out_true_r  <= pend_true_r;
      out_cell_r  <= cell_inc;
      out_corr_r  <= (pend_pred_r == pend_true_r) ? diag_inc : diag_r;
      out_total_r <= total_inc;
      out_acc_r   <= '0;
    end else if (ans_fire) begin
      out_kind_r  <= cma_pkg::KIND_READ;
      out_pred_r  <= '0;
      out_true_r  <= '0;
      out_cell_r  <= cell_cur;
      out_corr_r  <= diag_r;
      out_total_r <= total_r;
      out_acc_r   <= dv.quot;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_kind       = out_kind_r;
  assign out_pred_class        = out_pred_r;
  assign out_true_class        = out_true_r;
  assign out_cell_count        = out_cell_r;
  assign out_correct_count     = out_corr_r;
  assign out_sample_total      = out_total_r;
  assign out_accuracy_fraction = out_acc_r;

endmodule
`default_nettype wire

[sv/cma_ram.sv]
`default_nettype none
module cma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/cma_argmax.sv]
`default_nettype none
module cma_argmax (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic signed [cma_pkg::SCORE_W-1:0] pred_score,
  input  wire logic signed [cma_pkg::SCORE_W-1:0] true_score,
  input  wire logic        [cma_pkg::CFG_W-1:0]   class_count,
  output cma_pkg::am_res_t                    res
);

  logic signed [cma_pkg::SCORE_W-1:0] best_pred_r, best_pred_nxt;
  logic signed [cma_pkg::SCORE_W-1:0] best_true_r, best_true_nxt;
  logic        [cma_pkg::IDX_W-1:0]   pred_idx_r, pred_idx_nxt;
  logic        [cma_pkg::IDX_W-1:0]   true_idx_r, true_idx_nxt;
  logic        [cma_pkg::IDX_W-1:0]   pos_r, pos_nxt;
  logic        [cma_pkg::CFG_W-1:0]   n_used;
  logic                               last;

  always_comb begin
    if (class_count < cma_pkg::CLASS_COUNT_MIN) begin
      n_used = cma_pkg::CLASS_COUNT_MIN;
    end else if (class_count > cma_pkg::CLASS_COUNT_MAX) begin
      n_used = cma_pkg::CLASS_COUNT_MAX;
    end else begin
      n_used = class_count;
    end
    last = (cma_pkg::CFG_W'(pos_r) + cma_pkg::CFG_W'(1)) >= n_used;

    best_pred_nxt = best_pred_r;
    best_true_nxt = best_true_r;
    pred_idx_nxt  = pred_idx_r;
    true_idx_nxt  = true_idx_r;
    if (pos_r == '0) begin
      best_pred_nxt = pred_score;
      best_true_nxt = true_score;
      pred_idx_nxt  = '0;
      true_idx_nxt  = '0;
    end else begin
      if (pred_score > best_pred_r) begin
        best_pred_nxt = pred_score;
        pred_idx_nxt  = pos_r;
      end
      if (true_score > best_true_r) begin
        best_true_nxt = true_score;
        true_idx_nxt  = pos_r;
      end
    end
    pos_nxt = last ? '0 : pos_r + cma_pkg::IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_pred_r <= '0;
      best_true_r <= '0;
      pred_idx_r  <= '0;
      true_idx_r  <= '0;
      pos_r       <= '0;
    end else if (step) begin
      best_pred_r <= best_pred_nxt;
      best_true_r <= best_true_nxt;
      pred_idx_r  <= pred_idx_nxt;
      true_idx_r  <= true_idx_nxt;
      pos_r       <= pos_nxt;
    end
  end

  assign res.last     = last;
  assign res.pred_idx = pred_idx_nxt;
  assign res.true_idx = true_idx_nxt;

endmodule
`default_nettype wire

[sv/cma_div.sv]
`default_nettype none
module cma_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [cma_pkg::COUNT_WIDTH-1:0] dividend,
  input  wire logic [cma_pkg::COUNT_WIDTH-1:0] divisor,
  output cma_pkg::div_res_t                    res
);

  logic [cma_pkg::COUNT_WIDTH:0]   rem_r, rem_nxt, shifted;
  logic [cma_pkg::COUNT_WIDTH-1:0] div_r;
  logic [cma_pkg::FRAC_W-1:0]      quot_r, quot_nxt;
  logic [cma_pkg::STEP_W-1:0]      cnt_r;
  logic                            run_r, done_r, zero_r, ge;

  // first step takes the integer bit, the rest shift in fraction bits
  always_comb begin
    shifted  = (cnt_r == '0) ? rem_r : {rem_r[cma_pkg::COUNT_WIDTH-1:0], 1'b0};
    ge       = shifted >= {1'b0, div_r};
    rem_nxt  = ge ? shifted - {1'b0, div_r} : shifted;
    quot_nxt = {quot_r[cma_pkg::FRAC_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + cma_pkg::STEP_W'(1);
      if (cnt_r == cma_pkg::STEP_W'(cma_pkg::FRAC_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, dividend};
      div_r  <= divisor;
      zero_r <= (divisor == '0);
      quot_r <= '0;
    end else if (run_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign res.done = done_r;
  assign res.quot = zero_r ? '0 : quot_r;

endmodule
`default_nettype wire

[sv/cma_checker.sv]
`default_nettype none
module cma_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic                                 out_result_kind,
  input wire logic [cma_pkg::IDX_W-1:0]            out_pred_class,
  input wire logic [cma_pkg::IDX_W-1:0]            out_true_class,
  input wire logic [cma_pkg::COUNT_WIDTH-1:0]      out_cell_count,
  input wire logic [cma_pkg::COUNT_WIDTH-1:0]      out_correct_count,
  input wire logic [cma_pkg::COUNT_WIDTH-1:0]      out_sample_total,
  input wire logic [cma_pkg::FRAC_W-1:0]           out_accuracy_fraction
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_count)
      && $stable(out_accuracy_fraction) && $stable(out_result_kind))
    else $error("output word changed while stalled");

  a_diag_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_correct_count <= out_sample_total)
    else $error("correct count above sample total");

  a_sample_no_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == cma_pkg::KIND_SAMPLE |-> out_accuracy_fraction == '0)
    else $error("sample word carries accuracy");

  a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == cma_pkg::KIND_READ |->
      out_pred_class == '0 && out_true_class == '0
      && out_accuracy_fraction <= cma_pkg::FRAC_W'(65536))
    else $error("bad read answer fields");

  a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_total == '0 |-> out_accuracy_fraction == '0
      && out_cell_count == '0)
    else $error("nonzero answer with empty matrix");

endmodule

bind confusion_matrix_accumulator cma_checker u_cma_checker (.*);
`default_nettype wire
